// ===== rtl/jse_pkg.sv =====
// Package with the command format, character constants and beat formatting functions.
`default_nettype none
package jse_pkg;

  // Characters written by the escaper.
  localparam logic [7:0] CharQuote  = 8'h22;
  localparam logic [7:0] CharBslash = 8'h5C;
  localparam logic [7:0] CharSlash  = 8'h2F;
  localparam logic [7:0] CharLowerU = 8'h75;
  localparam logic [7:0] CharZero   = 8'h30;
  localparam logic [7:0] CharLowerA = 8'h61;

  // Opcode of an input beat.
  localparam logic OpData = 1'b0;
  localparam logic OpEnd  = 1'b1;

  // What the back end has to write for one accepted input beat.
  typedef enum logic [2:0] {
    CMD_NONE,
    CMD_CHAR,
    CMD_ESC,
    CMD_UNI,
    CMD_ERR
  } cmd_kind_e;

  typedef struct packed {
    logic        open_quote;
    cmd_kind_e   kind;
    logic [15:0] data;
  } cmd_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last;
    logic       err;
  } beat_t;

  // Letter that follows the backslash, or zero if the byte needs no escape.
  function automatic logic [7:0] escape_letter(logic [7:0] b);
    logic [7:0] e;
    unique case (b)
      8'h22:   e = CharQuote;
      8'h5C:   e = CharBslash;
      8'h2F:   e = CharSlash;
      8'h0A:   e = 8'h6E;  // n
      8'h09:   e = 8'h74;  // t
      8'h0D:   e = 8'h72;  // r
      8'h0C:   e = 8'h66;  // f
      8'h08:   e = 8'h62;  // b
      default: e = 8'h00;
    endcase
    return e;
  endfunction

  // Lowercase hex digit of a nibble.
  function automatic logic [7:0] hex_char(logic [3:0] d);
    logic [7:0] c;
    if (d < 4'd10) begin
      c = CharZero + {4'b0, d};
    end else begin
      c = CharLowerA + {4'b0, d} - 8'd10;
    end
    return c;
  endfunction

  // Number of output beats of a command.
  function automatic logic [2:0] cmd_count(cmd_t c);
    logic [2:0] n;
    unique case (c.kind)
      CMD_CHAR: n = 3'd1;
      CMD_ESC:  n = 3'd2;
      CMD_UNI:  n = 3'd6;
      CMD_ERR:  n = 3'd1;
      default:  n = 3'd0;
    endcase
    return n + {2'b0, c.open_quote};
  endfunction

  // Output beat number idx of a command.
  function automatic beat_t cmd_beat(cmd_t c, logic [2:0] idx);
    logic [2:0] j;
    beat_t      b;
    j = idx - {2'b0, c.open_quote};
    b.out_byte = 8'h00;
    b.err      = 1'b0;
    if (c.open_quote && idx == 3'd0) begin
      b.out_byte = CharQuote;
    end else begin
      unique case (c.kind)
        CMD_CHAR: b.out_byte = c.data[7:0];
        CMD_ESC:  b.out_byte = (j == 3'd0) ? CharBslash : c.data[7:0];
        CMD_UNI: begin
          case (j)
            3'd0:    b.out_byte = CharBslash;
            3'd1:    b.out_byte = CharLowerU;
            3'd2:    b.out_byte = hex_char(c.data[15:12]);
            3'd3:    b.out_byte = hex_char(c.data[11:8]);
            3'd4:    b.out_byte = hex_char(c.data[7:4]);
            default: b.out_byte = hex_char(c.data[3:0]);
          endcase
        end
        CMD_ERR:  b.err = 1'b1;
        default:  b.out_byte = 8'h00;
      endcase
    end
    b.last = (idx == cmd_count(c) - 3'd1);
    return b;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/jse_if.sv =====
// Stream interfaces for the input and output channels of the escaper.
`default_nettype none
interface jse_in_if;
  logic       valid;
  logic       ready;
  logic       opcode;
  logic [7:0] data_byte;

  modport source (output valid, output opcode, output data_byte, input ready);
  modport sink (input valid, input opcode, input data_byte, output ready);
endinterface

interface jse_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last_of_run;
  logic       invalid_unicode;

  modport source (output valid, output out_byte, output last_of_run,
                  output invalid_unicode, input ready);
  modport sink (input valid, input out_byte, input last_of_run,
                input invalid_unicode, output ready);
endinterface
`default_nettype wire

// ===== rtl/jse_front.sv =====
// Front end: accepts input beats, tracks the UTF-8 decoder state and issues commands.
`default_nettype none
module jse_front
  import jse_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  jse_in_if.sink    in_if,
  input  wire logic full_i,
  output logic      push_o,
  output cmd_t      cmd_o
);

  logic        open_q, open_d;
  logic [1:0]  pend_q, pend_d;
  logic [15:0] acc_q, acc_d;
  logic [15:0] acc_shift;
  logic [1:0]  pend_dec;
  logic [7:0]  letter;
  logic        accept;

  assign in_if.ready = ~full_i;
  assign accept      = in_if.valid & ~full_i;
  assign acc_shift   = {acc_q[9:0], in_if.data_byte[5:0]};
  assign pend_dec    = pend_q - 2'd1;
  assign letter      = escape_letter(in_if.data_byte);

  // Classify the beat and compute the next decoder state.
  always_comb begin
    open_d           = open_q;
    pend_d           = pend_q;
    acc_d            = acc_q;
    cmd_o.open_quote = ~open_q;
    cmd_o.kind       = CMD_NONE;
    cmd_o.data       = {8'h00, in_if.data_byte};
    if (in_if.opcode == OpEnd) begin
      if (pend_q != 2'd0) begin
        cmd_o.open_quote = 1'b0;
        cmd_o.kind       = CMD_ERR;
      end else begin
        cmd_o.kind = CMD_CHAR;
        cmd_o.data = {8'h00, CharQuote};
      end
      open_d = 1'b0;
      pend_d = 2'd0;
      acc_d  = 16'h0000;
    end else begin
      open_d = 1'b1;
      if (pend_q != 2'd0) begin
        if (!in_if.data_byte[7]) begin
          cmd_o.kind = CMD_ERR;
          open_d     = 1'b0;
          pend_d     = 2'd0;
          acc_d      = 16'h0000;
        end else if (pend_dec == 2'd0) begin
          cmd_o.kind = CMD_UNI;
          cmd_o.data = acc_shift;
          pend_d     = 2'd0;
          acc_d      = 16'h0000;
        end else begin
          pend_d = pend_dec;
          acc_d  = acc_shift;
        end
      end else if (in_if.data_byte[7]) begin
        if (in_if.data_byte[7:5] == 3'b111) begin
          pend_d = 2'd2;
          acc_d  = {12'h000, in_if.data_byte[3:0]};
        end else if (in_if.data_byte[7:6] == 2'b11) begin
          pend_d = 2'd1;
          acc_d  = {11'h000, in_if.data_byte[4:0]};
        end else begin
          cmd_o.kind = CMD_ERR;
          open_d     = 1'b0;
          pend_d     = 2'd0;
          acc_d      = 16'h0000;
        end
      end else if (letter != 8'h00) begin
        cmd_o.kind = CMD_ESC;
        cmd_o.data = {8'h00, letter};
      end else begin
        cmd_o.kind = CMD_CHAR;
      end
    end
  end

  // Only beats that produce output go into the queue.
  assign push_o = accept & (cmd_o.open_quote | (cmd_o.kind != CMD_NONE));

  // Decoder state registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      open_q <= 1'b0;
      pend_q <= 2'd0;
      acc_q  <= 16'h0000;
    end else if (accept) begin
      open_q <= open_d;
      pend_q <= pend_d;
      acc_q  <= acc_d;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/jse_fifo.sv =====
// Command queue between the front and back ends.
`default_nettype none
module jse_fifo
  import jse_pkg::*;
#(
  parameter int unsigned Depth = 4
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_i,
  input  cmd_t      cmd_i,
  output logic      full_o,
  input  wire logic pop_i,
  output logic      empty_o,
  output cmd_t      cmd_o
);

  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW  = $clog2(Depth + 1);
  localparam logic [AddrW-1:0] LastAddr = AddrW'(Depth - 1);

  cmd_t             mem_q [Depth];
  logic [AddrW-1:0] wr_q, rd_q;
  logic [CntW-1:0]  cnt_q;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign cmd_o   = mem_q[rd_q];

  // Storage; no reset needed on the payload.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= cmd_i;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= (wr_q == LastAddr) ? '0 : wr_q + AddrW'(1);
      end
      if (pop_i) begin
        rd_q <= (rd_q == LastAddr) ? '0 : rd_q + AddrW'(1);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (!push_i && pop_i) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

endmodule
`default_nettype wire

// ===== rtl/jse_back.sv =====
// Back end: expands each command into output beats through an output register.
`default_nettype none
module jse_back
  import jse_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic empty_i,
  input  cmd_t      cmd_i,
  output logic      pop_o,
  jse_out_if.source out_if
);

  logic       valid_q;
  logic [2:0] idx_q;
  beat_t      beat_q;
  beat_t      beat;
  logic       load;

  assign beat  = cmd_beat(cmd_i, idx_q);
  assign load  = ~empty_i & (~valid_q | out_if.ready);
  assign pop_o = load & beat.last;

  assign out_if.valid           = valid_q;
  assign out_if.out_byte        = beat_q.out_byte;
  assign out_if.last_of_run     = beat_q.last;
  assign out_if.invalid_unicode = beat_q.err;

  // Beat counter within the current command and the output valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      idx_q   <= 3'd0;
    end else begin
      if (load) begin
        valid_q <= 1'b1;
        idx_q   <= beat.last ? 3'd0 : idx_q + 3'd1;
      end else if (out_if.ready) begin
        valid_q <= 1'b0;
      end
    end
  end

  // Output payload register.
  always_ff @(posedge clk_i) begin
    if (load) begin
      beat_q <= beat;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/json_string_escaper_top.sv =====
// Top level of the JSON string escaper.
// Accepts one input beat per cycle while the command queue (QueueDepth entries) has room; an
// input beat yields k output beats (k from 0 to 6), so plain bytes stream at one beat per cycle
// while the output is ready, and escapes are limited by the output register, which issues one
// beat per cycle while the output is ready. Input ready drops only when the queue is full.
`default_nettype none
module json_string_escaper_top
  import jse_pkg::*;
#(
  parameter int unsigned QueueDepth = 4
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  jse_in_if.sink    in_if,
  jse_out_if.source out_if
);

  logic push, full, pop, empty;
  cmd_t cmd_in, cmd_out;

  jse_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_if  (in_if),
    .full_i (full),
    .push_o (push),
    .cmd_o  (cmd_in)
  );

  jse_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (cmd_in),
    .full_o  (full),
    .pop_i   (pop),
    .empty_o (empty),
    .cmd_o   (cmd_out)
  );

  jse_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .empty_i (empty),
    .cmd_i   (cmd_out),
    .pop_o   (pop),
    .out_if  (out_if)
  );

endmodule
`default_nettype wire

// ===== rtl/jse_checker.sv =====
// Port-level assertions for the escaper and their binding to the top level.
`default_nettype none
module jse_port_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       out_valid_i,
  input wire logic       out_ready_i,
  input wire logic [7:0] out_byte_i,
  input wire logic       out_last_i,
  input wire logic       out_invalid_i
);

  // The output register is cleared while reset is held.
  assert property (@(posedge clk_i) !rst_ni |-> !out_valid_i)
    else $error("output valid during reset");

  // A stalled beat keeps its payload.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_byte_i)
      && $stable(out_last_i) && $stable(out_invalid_i))
    else $error("stalled output beat changed");

  // An error beat is a zero byte and always ends its run.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_invalid_i |-> out_byte_i == 8'h00 && out_last_i)
    else $error("malformed error beat");

  // The rest of a run follows without a gap.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_ready_i && !out_last_i |=> out_valid_i)
    else $error("gap inside an output run");

endmodule

bind json_string_escaper_top jse_port_checker u_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .out_valid_i   (out_if.valid),
  .out_ready_i   (out_if.ready),
  .out_byte_i    (out_if.out_byte),
  .out_last_i    (out_if.last_of_run),
  .out_invalid_i (out_if.invalid_unicode)
);
`default_nettype wire
